// File: sv/llhp_pkg.sv
// Shared types and constants for the least-loaded host placer.
// Holds payload structs, result codes and the controller/datapath command
// and status structs. No dependencies.
package llhp_pkg;

	localparam int MAX_HOSTS = 64;
	localparam int ADDR_W    = $clog2(MAX_HOSTS);
	localparam int CNT_W     = $clog2(MAX_HOSTS + 1);
	localparam int LOAD_W    = 16;
	localparam int NUM_W     = 16;

	localparam logic [LOAD_W-1:0] CAPACITY_RESET = 16'd10;

	// item actions
	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_PLACE = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// result codes
	localparam logic [2:0] ST_LOADED     = 3'd0;
	localparam logic [2:0] ST_PLACED     = 3'd1;
	localparam logic [2:0] ST_REJECTED   = 3'd2;
	localparam logic [2:0] ST_FULL_EMPTY = 3'd3;
	localparam logic [2:0] ST_CLEARED    = 3'd4;

	typedef struct packed {
		logic [1:0]        action;
		logic [LOAD_W-1:0] amount;
	} item_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [NUM_W-1:0]  vm_number;
		logic [LOAD_W-1:0] previous_load;
		logic [LOAD_W-1:0] new_load;
	} result_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_PUSH_RD,
		OP_PUSH_CMP,
		OP_ROOT_RD,
		OP_ROOT_CMP,
		OP_SIFT_RD,
		OP_SIFT_CMP
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   finish;   // result is formed this cycle
	} dp_cmd_t;

	typedef struct packed {
		logic heap_full;
		logic heap_empty;
		logic pos_zero;   // sift-up reached the root
		logic parent_gt;  // parent strictly above the new load
		logic fits;       // root + demand within capacity
		logic leaf;       // sift position has no child
		logic stop;       // sifted value strictly below the smaller child
	} dp_sts_t;

endpackage

// File: sv/least_loaded_host_placer_core.sv
// Least-loaded host placer, top level.
// Joins the sequencer (llhp_ctrl) and the datapath (llhp_dp); uses llhp_pkg.
//
// Usage:
//  - Item channel: an item transfers on a rising edge with start high and
//    busy low. action LOAD inserts a host load into the min-heap, PLACE
//    offers a VM demand to the least-loaded host, CLEAR empties the heap
//    and restarts VM numbering. The unused action code is taken and dropped.
//  - Result channel: every LOAD, PLACE and CLEAR item yields one result,
//    shown on result for exactly one cycle with done high. The receiver
//    cannot stall, so results are never held or lost.
//  - Config: cfg_we writes cfg_wdata to the capacity register on the edge.
//    Write only while the block is idle.
//  - Steps from transfer to done: CLEAR, heap-full LOAD and empty-heap
//    PLACE finish at the transfer; a LOAD climbs a level per parent read
//    and compare/write until it reaches the root or a parent not above it;
//    a PLACE reads and compares the root, ending there if rejected, else it
//    sifts down a level per child read and compare/write until it reaches a
//    leaf or is below the smaller child. Each level costs a registered
//    memory read and a compare/write step through the single heap RAM.
//  - busy drops the cycle done rises, so the next item may transfer then.
//  - Reset empties the heap, zeroes VM numbering and sets capacity to 10;
//    heap memory itself is not cleared, only entries below the count are read.
module least_loaded_host_placer_core import llhp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  item_t             item,
	input  logic              cfg_we,
	input  logic [LOAD_W-1:0] cfg_wdata,
	output logic              done,
	output result_t           result
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencer: walks the heap one level per read state and compare/write state
	llhp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (item.action),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	// datapath: heap RAM, counters, capacity and result register
	llhp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.done      (done),
		.result    (result)
	);

endmodule

// File: sv/llhp_ctrl.sv
// Sequencer for the least-loaded host placer.
// One-hot state machine issuing datapath commands; uses llhp_pkg.
module llhp_ctrl import llhp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] action,
	input  dp_sts_t    sts,
	output logic       busy,
	output dp_cmd_t    cmd
);

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_PUSH_RD  = 7'b0000010,
		S_PUSH_CMP = 7'b0000100,
		S_ROOT_RD  = 7'b0001000,
		S_ROOT_CMP = 7'b0010000,
		S_SIFT_RD  = 7'b0100000,
		S_SIFT_CMP = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d    = state_q;
		cmd.op     = OP_NONE;
		cmd.finish = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op = OP_ACCEPT;
					priority case (action)
						ACT_LOAD: begin
							if (sts.heap_full) cmd.finish = 1'b1;
							else               state_d    = S_PUSH_RD;
						end
						ACT_PLACE: begin
							if (sts.heap_empty) cmd.finish = 1'b1;
							else                state_d    = S_ROOT_RD;
						end
						ACT_CLEAR: cmd.finish = 1'b1;
						default: ;   // unused action: no effect, no result
					endcase
				end
			end
			S_PUSH_RD: begin
				cmd.op = OP_PUSH_RD;
				if (sts.pos_zero) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end else begin
					state_d = S_PUSH_CMP;
				end
			end
			S_PUSH_CMP: begin
				cmd.op = OP_PUSH_CMP;
				if (sts.parent_gt) begin
					state_d = S_PUSH_RD;
				end else begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_ROOT_RD: begin
				cmd.op  = OP_ROOT_RD;
				state_d = S_ROOT_CMP;
			end
			S_ROOT_CMP: begin
				cmd.op = OP_ROOT_CMP;
				if (sts.fits) begin
					state_d = S_SIFT_RD;
				end else begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_SIFT_RD: begin
				cmd.op = OP_SIFT_RD;
				if (sts.leaf) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end else begin
					state_d = S_SIFT_CMP;
				end
			end
			S_SIFT_CMP: begin
				cmd.op = OP_SIFT_CMP;
				if (sts.stop) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end else begin
					state_d = S_SIFT_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_finish_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> state_q == S_IDLE)
		else $error("controller did not return to idle after a result");

endmodule

// File: sv/llhp_dp.sv
// Datapath for the least-loaded host placer: heap memory, counters,
// capacity register and result register. Uses llhp_pkg.
module llhp_dp import llhp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  item_t             item,
	input  logic              cfg_we,
	input  logic [LOAD_W-1:0] cfg_wdata,
	input  dp_cmd_t           cmd,
	output dp_sts_t           sts,
	output logic              done,
	output result_t           result
);

	localparam int KID_W = ADDR_W + 2;

	logic [LOAD_W-1:0] heap_q [MAX_HOSTS];
	logic [LOAD_W-1:0] rd_a_q, rd_b_q;

	logic [CNT_W-1:0]  count_q;
	logic [NUM_W-1:0]  counter_q;
	logic [LOAD_W-1:0] capacity_q;
	logic [ADDR_W-1:0] pos_q;
	logic [LOAD_W-1:0] value_q;
	logic [1:0]        action_q;
	logic [NUM_W-1:0]  number_q;
	logic [LOAD_W-1:0] prev_q, new_q;
	logic              done_q;
	result_t           result_q;

	logic [ADDR_W-1:0] pos_m1, parent_addr, ra, rb, chosen_idx, wa;
	logic [KID_W-1:0]  child_w, child_p1, cnt_ext;
	logic [LOAD_W:0]   sum;
	logic              right_ok, use_right, we;
	logic [LOAD_W-1:0] chosen, wd;
	logic [2:0]        res_status;
	logic [NUM_W-1:0]  res_number;
	logic [NUM_W-1:0]  counter_inc;

	// heap addressing
	assign pos_m1      = pos_q - ADDR_W'(1);
	assign parent_addr = {1'b0, pos_m1[ADDR_W-1:1]};
	assign child_w     = {1'b0, pos_q, 1'b1};
	assign child_p1    = child_w + KID_W'(1);
	assign cnt_ext     = {{(KID_W-CNT_W){1'b0}}, count_q};
	assign rb          = child_p1[ADDR_W-1:0];
	assign sum         = {1'b0, rd_a_q} + {1'b0, value_q};
	assign counter_inc = counter_q + NUM_W'(1);

	always_comb begin
		right_ok = (child_p1 < cnt_ext);
		use_right = 1'b0;
		if (right_ok) use_right = (rd_b_q < rd_a_q);
		chosen     = use_right ? rd_b_q : rd_a_q;
		chosen_idx = use_right ? rb : child_w[ADDR_W-1:0];
	end

	assign sts.heap_full  = (count_q == CNT_W'(MAX_HOSTS));
	assign sts.heap_empty = (count_q == '0);
	assign sts.pos_zero   = (pos_q == '0);
	assign sts.parent_gt  = (rd_a_q > value_q);
	assign sts.fits       = (sum <= {1'b0, capacity_q});
	assign sts.leaf       = (child_w >= cnt_ext);
	assign sts.stop       = (value_q < chosen);

	// memory ports
	always_comb begin
		we = 1'b0;
		wa = pos_q;
		wd = value_q;
		ra = '0;
		unique case (cmd.op)
			OP_PUSH_RD: begin
				ra = parent_addr;
				we = sts.pos_zero;
			end
			OP_PUSH_CMP: begin
				we = 1'b1;
				wd = sts.parent_gt ? rd_a_q : value_q;
			end
			OP_SIFT_RD: begin
				ra = child_w[ADDR_W-1:0];
				we = sts.leaf;
			end
			OP_SIFT_CMP: begin
				we = 1'b1;
				wd = sts.stop ? value_q : chosen;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) heap_q[wa] <= wd;
		rd_a_q <= heap_q[ra];
		rd_b_q <= heap_q[rb];
	end

	// result code and number for the finishing step
	always_comb begin
		res_number = number_q;
		unique case (cmd.op)
			OP_ACCEPT: begin
				res_status = (item.action == ACT_CLEAR) ? ST_CLEARED : ST_FULL_EMPTY;
				res_number = (item.action == ACT_PLACE) ? counter_inc : '0;
			end
			OP_PUSH_RD, OP_PUSH_CMP: res_status = ST_LOADED;
			OP_ROOT_CMP:             res_status = ST_REJECTED;
			OP_SIFT_RD, OP_SIFT_CMP: res_status = ST_PLACED;
			default:                 res_status = ST_FULL_EMPTY;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			counter_q  <= '0;
			capacity_q <= CAPACITY_RESET;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cfg_we) capacity_q <= cfg_wdata;
			if (cmd.op == OP_ACCEPT) begin
				if (item.action == ACT_PLACE) begin
					counter_q <= counter_inc;
				end else if (item.action == ACT_CLEAR) begin
					count_q   <= '0;
					counter_q <= '0;
				end
			end
			if (cmd.finish && (cmd.op == OP_PUSH_RD || cmd.op == OP_PUSH_CMP))
				count_q <= count_q + CNT_W'(1);
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_ACCEPT: begin
				value_q  <= item.amount;
				action_q <= item.action;
				prev_q   <= '0;
				new_q    <= '0;
				pos_q    <= count_q[ADDR_W-1:0];
				number_q <= (item.action == ACT_PLACE) ? counter_inc : '0;
			end
			OP_PUSH_CMP: begin
				if (sts.parent_gt) pos_q <= parent_addr;
			end
			OP_ROOT_CMP: begin
				if (sts.fits) begin
					value_q <= sum[LOAD_W-1:0];
					prev_q  <= rd_a_q;
					new_q   <= sum[LOAD_W-1:0];
					pos_q   <= '0;
				end
			end
			OP_SIFT_CMP: begin
				if (!sts.stop) pos_q <= chosen_idx;
			end
			default: ;
		endcase
		if (cmd.finish) begin
			result_q.status        <= res_status;
			result_q.vm_number     <= res_number;
			result_q.previous_load <= (cmd.op == OP_ACCEPT) ? '0 : prev_q;
			result_q.new_load      <= (cmd.op == OP_ACCEPT) ? '0 : new_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_HOSTS))
		else $error("host count beyond heap size");

	a_placed_grows: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && result_q.status == ST_PLACED |->
			result_q.new_load >= result_q.previous_load)
		else $error("placement lowered a host load");

	a_unplaced_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && result_q.status != ST_PLACED |->
			result_q.previous_load == '0 && result_q.new_load == '0)
		else $error("loads reported for an item that placed nothing");

	a_place_numbered: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (result_q.status == ST_PLACED || result_q.status == ST_REJECTED) |->
			action_q == ACT_PLACE && result_q.vm_number == counter_q)
		else $error("place result number out of step with request counter");

endmodule
